// ----- hdl/text_console_char_writer_defines.svh -----
// ----------------------------------------------------------------------------
// text console assertion macros
// shared helpers for the concurrent checks of the console writer
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH

// same-cycle implication
`define TCCW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tccw check failed");

// next-cycle implication
`define TCCW_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tccw check failed");

`endif

// ----- hdl/tccw_pkg.sv -----
// ----------------------------------------------------------------------------
// tccw_pkg
// constants shared by the text console writer and its screen store
// ----------------------------------------------------------------------------
package tccw_pkg;

  localparam int unsigned CELL_W = 16;

  // cleared cell: space with gray-on-black attribute
  localparam logic [7:0]        ATTR_RESET = 8'h07;
  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;

  // control codes
  localparam logic [7:0] CH_BEL = 8'h07;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_CR  = 8'h0D;

  // item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

endpackage

// ----- hdl/tccw_screen_ram.sv -----
// ----------------------------------------------------------------------------
// tccw_screen_ram
// character/attribute store, one write port and one registered read port
// ----------------------------------------------------------------------------
module tccw_screen_ram #(
  parameter int unsigned DEPTH  = 2000,
  parameter int unsigned ADDR_W = 11
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [ADDR_W-1:0]           waddr_i,
  input  logic [tccw_pkg::CELL_W-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [ADDR_W-1:0]           raddr_i,
  output logic [tccw_pkg::CELL_W-1:0] rdata_o
);

  logic [tccw_pkg::CELL_W-1:0] mem [DEPTH];
  logic [tccw_pkg::CELL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/text_console_char_writer.sv -----
// ----------------------------------------------------------------------------
// text_console_char_writer
// text-mode console: screen store of COLUMNS x ROWS cells plus a cursor
// ----------------------------------------------------------------------------
// After reset the store is cleared by a pass over all COLUMNS*ROWS cells,
// one per cycle, and input stays stalled until that pass and the drain state
// are over; the attribute register can be written throughout. Printable
// characters, the bell and control codes that only move the cursor are taken
// and their result is registered at the edge that takes them. A read of a
// cell inside the screen goes through the registered store read and the READ
// state; one outside the screen finishes at the edge that takes it. Form feed,
// and any newline, tab or line wrap that scrolls, run the single address/copy
// sequencer over every cell, one per cycle, then its drain state. The result
// register lets a new item be taken in the cycle the previous result leaves.
// ----------------------------------------------------------------------------
module text_console_char_writer #(
  parameter int unsigned COLUMNS   = 80,
  parameter int unsigned ROWS      = 25,
  parameter int unsigned TAB_WIDTH = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration
  input  logic       text_attribute_we_i,
  input  logic [7:0] text_attribute_i,
  // input items
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       kind_i,
  input  logic [7:0] char_code_i,
  input  logic [6:0] read_col_i,
  input  logic [4:0] read_row_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [6:0]  cursor_col_o,
  output logic [4:0]  cursor_row_o,
  output logic [10:0] cursor_offset_o,
  output logic        beep_o,
  output logic [7:0]  cell_char_o,
  output logic [7:0]  cell_attr_o
);

  localparam int unsigned CELLS    = COLUMNS * ROWS;
  localparam int unsigned ADDR_W   = $clog2(CELLS);
  localparam int unsigned COL_W    = $clog2(COLUMNS);
  localparam int unsigned ROW_W    = $clog2(ROWS);
  localparam int unsigned TS_W     = $clog2(COLUMNS + TAB_WIDTH);
  localparam int unsigned COPY_END = CELLS - COLUMNS;
  localparam int unsigned OFF_X    = (ADDR_W > 11) ? ADDR_W : 11;
  localparam int unsigned ROW_X    = (ROW_W > 5) ? ROW_W : 5;

  localparam int unsigned ST_W = 2;
  localparam logic [ST_W-1:0] ST_IDLE  = 2'd0;
  localparam logic [ST_W-1:0] ST_READ  = 2'd1;
  localparam logic [ST_W-1:0] ST_SWEEP = 2'd2;
  localparam logic [ST_W-1:0] ST_DRAIN = 2'd3;

  logic [ST_W-1:0]   state_q, state_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [ADDR_W-1:0] base_q, base_d;
  logic [7:0]        attr_q, attr_d;
  logic [ADDR_W-1:0] ptr_q, ptr_d;
  logic              copy_q, copy_d;
  logic              respond_q, respond_d;
  logic              pend_valid_q, pend_valid_d;
  logic [ADDR_W-1:0] pend_addr_q, pend_addr_d;
  logic              pend_blank_q, pend_blank_d;

  logic              out_valid_q, out_valid_d;
  logic [6:0]        out_col_q;
  logic [4:0]        out_row_q;
  logic [10:0]       out_off_q;
  logic              out_beep_q;
  logic [7:0]        out_char_q, out_attr_q;

  logic              finish, fin_beep;
  logic [7:0]        fin_char, fin_attr;
  logic              accept;

  logic                        ram_we, ram_re;
  logic [ADDR_W-1:0]           ram_waddr, ram_raddr;
  logic [tccw_pkg::CELL_W-1:0] ram_wdata, ram_rdata;

  logic              in_range;
  logic [ADDR_W-1:0] rd_addr;
  logic              nl_scroll;
  logic              copy_now;
  logic [ADDR_W-1:0] off_sum;
  logic [OFF_X-1:0]  off_x;
  logic [ROW_X-1:0]  row_x;

  // next tab stop for every column
  logic [TS_W-1:0] tab_stop [COLUMNS];
  for (genvar c = 0; c < COLUMNS; c++) begin : g_tab
    assign tab_stop[c] = TS_W'((c / TAB_WIDTH + 1) * TAB_WIDTH);
  end

  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  assign in_range  = ({1'b0, read_col_i} < 8'(COLUMNS)) && ({2'b0, read_row_i} < 7'(ROWS));
  assign rd_addr   = ADDR_W'(32'(read_row_i) * COLUMNS + 32'(read_col_i));
  assign nl_scroll = (row_q == ROW_W'(ROWS - 1));
  assign copy_now  = copy_q && (ptr_q < ADDR_W'(COPY_END));

  always_comb begin
    state_d      = state_q;
    col_d        = col_q;
    row_d        = row_q;
    base_d       = base_q;
    attr_d       = attr_q;
    ptr_d        = ptr_q;
    copy_d       = copy_q;
    respond_d    = respond_q;
    pend_valid_d = 1'b0;
    pend_addr_d  = pend_addr_q;
    pend_blank_d = pend_blank_q;
    finish       = 1'b0;
    fin_beep     = 1'b0;
    fin_char     = 8'h00;
    fin_attr     = 8'h00;
    ram_we       = 1'b0;
    ram_waddr    = pend_addr_q;
    ram_wdata    = pend_blank_q ? tccw_pkg::BLANK_CELL : ram_rdata;
    ram_re       = 1'b0;
    ram_raddr    = rd_addr;

    if (text_attribute_we_i) begin
      attr_d = text_attribute_i;
    end

    // delayed half of the sweep: write the cell that the registered read returned, or a blank
    if (pend_valid_q) begin
      ram_we = 1'b1;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (kind_i == tccw_pkg::KIND_READ) begin
            if (in_range) begin
              ram_re  = 1'b1;
              state_d = ST_READ;
            end else begin
              finish = 1'b1;
            end
          end else begin
            finish = 1'b1;
            case (char_code_i)
              tccw_pkg::CH_LF: begin
                col_d = '0;
                if (nl_scroll) begin
                  finish    = 1'b0;
                  ptr_d     = '0;
                  copy_d    = 1'b1;
                  respond_d = 1'b1;
                  state_d   = ST_SWEEP;
                end else begin
                  row_d  = row_q + 1'b1;
                  base_d = base_q + ADDR_W'(COLUMNS);
                end
              end
              tccw_pkg::CH_FF: begin
                finish    = 1'b0;
                col_d     = '0;
                row_d     = '0;
                base_d    = '0;
                ptr_d     = '0;
                copy_d    = 1'b0;
                respond_d = 1'b1;
                state_d   = ST_SWEEP;
              end
              tccw_pkg::CH_BS: begin
                if (col_q != '0) begin
                  col_d = col_q - 1'b1;
                end
              end
              tccw_pkg::CH_CR: begin
                col_d = '0;
              end
              tccw_pkg::CH_TAB: begin
                if (tab_stop[col_q] >= TS_W'(COLUMNS)) begin
                  col_d = '0;
                  if (nl_scroll) begin
                    finish    = 1'b0;
                    ptr_d     = '0;
                    copy_d    = 1'b1;
                    respond_d = 1'b1;
                    state_d   = ST_SWEEP;
                  end else begin
                    row_d  = row_q + 1'b1;
                    base_d = base_q + ADDR_W'(COLUMNS);
                  end
                end else begin
                  col_d = COL_W'(tab_stop[col_q]);
                end
              end
              tccw_pkg::CH_BEL: begin
                fin_beep = 1'b1;
              end
              default: begin
                ram_we    = 1'b1;
                ram_waddr = base_q + ADDR_W'(col_q);
                ram_wdata = {attr_q, char_code_i};
                if (col_q == COL_W'(COLUMNS - 1)) begin
                  col_d = '0;
                  if (nl_scroll) begin
                    finish    = 1'b0;
                    ptr_d     = '0;
                    copy_d    = 1'b1;
                    respond_d = 1'b1;
                    state_d   = ST_SWEEP;
                  end else begin
                    row_d  = row_q + 1'b1;
                    base_d = base_q + ADDR_W'(COLUMNS);
                  end
                end else begin
                  col_d = col_q + 1'b1;
                end
              end
            endcase
          end
        end
      end
      ST_READ: begin
        finish   = 1'b1;
        fin_char = ram_rdata[7:0];
        fin_attr = ram_rdata[15:8];
        state_d  = ST_IDLE;
      end
      ST_SWEEP: begin
        // rows below move up one row; the last row (or every row on clear) blanks
        ram_re       = copy_now;
        ram_raddr    = ptr_q + ADDR_W'(COLUMNS);
        pend_valid_d = 1'b1;
        pend_addr_d  = ptr_q;
        pend_blank_d = !copy_now;
        if (ptr_q == ADDR_W'(CELLS - 1)) begin
          state_d = ST_DRAIN;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        finish  = respond_q;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign off_sum = base_d + ADDR_W'(col_d);
  assign off_x   = OFF_X'(off_sum);
  assign row_x   = ROW_X'(row_d);

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (finish) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_SWEEP;
      col_q        <= '0;
      row_q        <= '0;
      base_q       <= '0;
      attr_q       <= tccw_pkg::ATTR_RESET;
      ptr_q        <= '0;
      copy_q       <= 1'b0;
      respond_q    <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      col_q        <= col_d;
      row_q        <= row_d;
      base_q       <= base_d;
      attr_q       <= attr_d;
      ptr_q        <= ptr_d;
      copy_q       <= copy_d;
      respond_q    <= respond_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_addr_q  <= pend_addr_d;
    pend_blank_q <= pend_blank_d;
    if (finish) begin
      out_col_q  <= 7'(col_d);
      out_row_q  <= row_x[4:0];
      out_off_q  <= off_x[10:0];
      out_beep_q <= fin_beep;
      out_char_q <= fin_char;
      out_attr_q <= fin_attr;
    end
  end

  tccw_screen_ram #(
    .DEPTH  (CELLS),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o     = out_valid_q;
  assign cursor_col_o    = out_col_q;
  assign cursor_row_o    = out_row_q;
  assign cursor_offset_o = out_off_q;
  assign beep_o          = out_beep_q;
  assign cell_char_o     = out_char_q;
  assign cell_attr_o     = out_attr_q;

endmodule

// ----- hdl/tccw_checker.sv -----
// ----------------------------------------------------------------------------
// tccw_checker
// port-level checks for the text console writer, bound to the top level
// ----------------------------------------------------------------------------
`include "text_console_char_writer_defines.svh"

module tccw_checker #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [6:0]  cursor_col_o,
  input logic [4:0]  cursor_row_o,
  input logic [10:0] cursor_offset_o,
  input logic        beep_o,
  input logic [7:0]  cell_char_o,
  input logic [7:0]  cell_attr_o
);

  // a waiting result holds
  `TCCW_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(cursor_offset_o) && $stable(cell_char_o) && $stable(beep_o))

  // no item is taken while a result is blocked
  `TCCW_ASSERT_IMP(a_no_take_when_full, clk_i, rst_ni, out_valid_o && out_stall_i,
    in_stall_o)

  // cursor column stays on the screen
  `TCCW_ASSERT_IMP(a_col_range, clk_i, rst_ni, out_valid_o,
    32'(cursor_col_o) < COLUMNS)

  // linear offset agrees with column and row
  `TCCW_ASSERT_IMP(a_offset, clk_i, rst_ni, out_valid_o && (ROWS <= 32),
    cursor_offset_o == 11'(32'(cursor_col_o) + COLUMNS * 32'(cursor_row_o)))

  // a bell result never carries cell data
  `TCCW_ASSERT_IMP(a_beep_no_cell, clk_i, rst_ni, out_valid_o && beep_o,
    (cell_char_o == 8'h00) && (cell_attr_o == 8'h00))

endmodule

bind text_console_char_writer tccw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tccw_checker (.*);
